[design/thermistor_temperature_alarm_macros.svh]
// Assertion shorthands for the thermistor alarm checks.
// Both expect clk and rst_n in scope.
`ifndef THERMISTOR_TEMPERATURE_ALARM_MACROS_SVH
`define THERMISTOR_TEMPERATURE_ALARM_MACROS_SVH

// Check a property at every clock edge outside reset.
`define TTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tta_pkg.sv]
`timescale 1ns / 1ps

package tta_pkg;

    localparam int ADC_BITS = 12;
    localparam int CHANNELS = 3;
    localparam int CH_W     = 2;

    localparam logic [ADC_BITS-1:0] ADC_FS = {ADC_BITS{1'b1}};
    localparam int R_DIV_W = 14;
    localparam logic [R_DIV_W-1:0] R_DIV = 14'd10000;
    localparam int X_W = ADC_BITS + R_DIV_W;

    localparam int P_W     = $clog2(X_W);
    localparam int FRAC_W  = 24;
    localparam int LOG_W   = P_W + FRAC_W;
    localparam int M_W     = 31;
    localparam int LOG_LAT = FRAC_W + 1;

    localparam int LN_W = LOG_W;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam int COEF_W = 48;
    localparam int HALF   = COEF_W / 2;
    localparam int L2_W   = 2 * LN_W - FRAC_W;
    localparam int L2_LO  = (L2_W + 1) / 2;
    localparam int BL_W   = COEF_W + LN_W - FRAC_W;
    localparam int L3_W   = L2_W + LN_W - FRAC_W;
    localparam int L3_LO  = (L3_W + 1) / 2;
    localparam int PC_W   = HALF + L3_LO;
    localparam int CLF_W  = COEF_W + L3_W;
    localparam int CL_W   = CLF_W - FRAC_W;
    localparam int SUM_W  = 64;

    localparam int Q_W      = 25;
    localparam int DIV_W    = 62;
    localparam int DIV_LAT  = Q_W;
    localparam int RECIP_SH = 56;
    localparam logic [DIV_W-1:0] R_INIT = DIV_W'(1) << (RECIP_SH - Q_W);
    localparam int T_W = Q_W + 2;
    localparam logic signed [T_W-1:0] ZERO_C = 27'sd17901158;

    localparam int NOM_W = 8;
    localparam int THR_W = 8;
    localparam int TMP_W = 8;
    localparam logic signed [TMP_W-1:0] TEMP_MAX = 8'sd127;
    localparam logic signed [TMP_W-1:0] TEMP_MIN = -8'sd128;

    localparam int ST_D    = LOG_LAT;
    localparam int ST_L    = ST_D + 1;
    localparam int ST_P1   = ST_L + 1;
    localparam int ST_P2   = ST_P1 + 1;
    localparam int ST_P3   = ST_P2 + 1;
    localparam int ST_P4   = ST_P3 + 1;
    localparam int ST_P5   = ST_P4 + 1;
    localparam int ST_INV  = ST_P5 + 1;
    localparam int ST_CLS  = ST_INV + 1;
    localparam int ST_DQ   = ST_CLS + DIV_LAT;
    localparam int ST_T    = ST_DQ + 1;
    localparam int META_N  = ST_T + 1;

    localparam int QDEPTH = 4;
    localparam int QP_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_A,
        REG_COEFF_B,
        REG_COEFF_C,
        REG_NOM0,
        REG_NOM1,
        REG_NOM2,
        REG_THRESHOLD
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]       coeff_a;
        logic signed [COEF_W-1:0]       coeff_b;
        logic signed [COEF_W-1:0]       coeff_c;
        logic [CHANNELS-1:0][NOM_W-1:0] nominal;
        logic [THR_W-1:0]               threshold;
    } cfg_t;

    localparam logic signed [COEF_W-1:0] COEF_RST = COEF_W'(1) << 40;

    localparam cfg_t CFG_RST = '{
        coeff_a:   COEF_RST,
        coeff_b:   COEF_RST,
        coeff_c:   COEF_RST,
        nominal:   {8'd15, 8'd3, 8'd8},
        threshold: 8'd10
    };

    typedef struct packed {
        logic [X_W-1:0]      x_hi;
        logic [ADC_BITS-1:0] x_lo;
        logic                inval;
        logic                chan_ok;
        logic [CH_W-1:0]     chan;
    } q_item_t;

    typedef struct packed {
        logic            vld;
        logic            inval;
        logic            chan_ok;
        logic [CH_W-1:0] chan;
        logic            sat_hi;
        logic            sat_lo;
    } meta_t;

    typedef struct packed {
        logic                    vld;
        logic signed [TMP_W-1:0] temperature;
        logic                    alarm;
        logic                    inval;
        logic [CH_W-1:0]         chan;
    } res_t;

endpackage

[design/tta_front.sv]
`timescale 1ns / 1ps

module tta_front import tta_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [ADC_BITS-1:0] adc_sample,
    input  logic [CH_W-1:0]     channel,
    output logic                full,
    input  logic                take,
    output q_item_t             head,
    output logic                head_vld
);

    q_item_t          item;
    q_item_t          q_mem [QDEPTH];
    logic [QP_W-1:0]  wr_ptr_reg;
    logic [QP_W-1:0]  rd_ptr_reg;
    logic [QC_W-1:0]  cnt_reg;
    logic [QC_W-1:0]  cnt_next;
    logic             wr;

    always_comb
    begin
        item.x_hi    = X_W'(X_W'(R_DIV) * X_W'(adc_sample));
        item.x_lo    = ADC_FS - adc_sample;
        item.inval   = (adc_sample == '0) || (adc_sample == ADC_FS);
        item.chan_ok = (32'(channel) < CHANNELS);
        item.chan    = channel;
    end

    assign full     = (cnt_reg == QC_W'(QDEPTH));
    assign wr       = push && !full;
    assign head     = q_mem[rd_ptr_reg];
    assign head_vld = (cnt_reg != '0);
    assign cnt_next = cnt_reg + QC_W'(wr) - QC_W'(take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (take)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            q_mem[wr_ptr_reg] <= item;
    end

endmodule

[design/tta_log2.sv]
`timescale 1ns / 1ps

module tta_log2 import tta_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [X_W-1:0]   x,
    output logic [LOG_W-1:0] lg
);

    logic [P_W-1:0]    p_reg [LOG_LAT];
    logic [M_W-1:0]    m_reg [LOG_LAT];
    logic [FRAC_W-1:0] f_reg [LOG_LAT];
    logic [P_W-1:0]    p_next;
    logic [M_W-1:0]    m_next;
    logic [2*M_W-1:0]  sq    [LOG_LAT];
    logic [M_W:0]      hi    [LOG_LAT];
    logic              sb    [LOG_LAT];

    always_comb
    begin
        p_next = '0;
        for (int i = 1; i < X_W; i++)
        begin
            if (x[i])
                p_next = P_W'(i);
        end
        m_next = M_W'(x) << (P_W'(M_W - 1) - p_next);
    end

    always_comb
    begin
        sq[0] = '0;
        hi[0] = '0;
        sb[0] = 1'b0;
        for (int i = 1; i < LOG_LAT; i++)
        begin
            sq[i] = (2*M_W)'(m_reg[i-1]) * (2*M_W)'(m_reg[i-1]);
            hi[i] = sq[i][2*M_W-1:M_W-1];
            sb[i] = hi[i][M_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= p_next;
            m_reg[0] <= m_next;
            f_reg[0] <= '0;
            for (int i = 1; i < LOG_LAT; i++)
            begin
                p_reg[i] <= p_reg[i-1];
                m_reg[i] <= sb[i] ? hi[i][M_W:1] : hi[i][M_W-1:0];
                f_reg[i] <= {f_reg[i-1][FRAC_W-2:0], sb[i]};
            end
        end
    end

    assign lg = {p_reg[LOG_LAT-1], f_reg[LOG_LAT-1]};

endmodule

[design/tta_recip.sv]
`timescale 1ns / 1ps

module tta_recip import tta_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [DIV_W-1:0] d,
    output logic [Q_W-1:0]   q
);

    logic [DIV_W-1:0] r_reg [DIV_LAT];
    logic [DIV_W-1:0] d_reg [DIV_LAT];
    logic [Q_W-1:0]   q_reg [DIV_LAT];
    logic [DIV_W-1:0] r_prv [DIV_LAT];
    logic [DIV_W-1:0] d_prv [DIV_LAT];
    logic [Q_W-1:0]   q_prv [DIV_LAT];
    logic [DIV_W:0]   t     [DIV_LAT];
    logic             ge    [DIV_LAT];
    logic [DIV_W-1:0] r_nx  [DIV_LAT];

    always_comb
    begin
        for (int i = 0; i < DIV_LAT; i++)
        begin
            r_prv[i] = (i == 0) ? R_INIT : r_reg[(i == 0) ? 0 : i-1];
            d_prv[i] = (i == 0) ? d : d_reg[(i == 0) ? 0 : i-1];
            q_prv[i] = (i == 0) ? '0 : q_reg[(i == 0) ? 0 : i-1];
            t[i]     = {r_prv[i], 1'b0};
            ge[i]    = (t[i] >= {1'b0, d_prv[i]});
            r_nx[i]  = ge[i] ? DIV_W'(t[i] - {1'b0, d_prv[i]}) : t[i][DIV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                r_reg[i] <= r_nx[i];
                d_reg[i] <= d_prv[i];
                q_reg[i] <= {q_prv[i][Q_W-2:0], ge[i]};
            end
        end
    end

    assign q = q_reg[DIV_LAT-1];

endmodule

[design/tta_back.sv]
`timescale 1ns / 1ps

module tta_back import tta_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  q_item_t head,
    input  logic    head_vld,
    output logic    take,
    input  logic    pop,
    output res_t    res
);

    logic adv;

    meta_t meta_reg [META_N];
    meta_t cls_meta;

    logic [LOG_W-1:0] lg_hi;
    logic [LOG_W-1:0] lg_lo;

    logic signed [LOG_W:0] d_w;
    logic [LN_W-1:0]       dmag_reg;
    logic                  dneg_reg;

    logic [LN_W+31:0]      ln_prod;
    logic [LN_W-1:0]       lmag_reg;
    logic                  lneg_reg;

    logic [2*LN_W-1:0]     l2_full;
    logic [COEF_W-1:0]     bmag;
    logic [L2_W-1:0]       l2mag_reg;
    logic [HALF+LN_W-1:0]  pb_lo_reg;
    logic [HALF+LN_W-1:0]  pb_hi_reg;
    logic [LN_W-1:0]       lmag_p1_reg;
    logic                  lneg_p1_reg;

    logic [COEF_W+LN_W-1:0] bl_full;
    logic [L2_LO+LN_W-1:0]  pl_lo_reg;
    logic [L2_LO+LN_W-1:0]  pl_hi_reg;
    logic [BL_W-1:0]        blmag_reg;
    logic                   blneg_reg;
    logic                   lneg_p2_reg;

    logic [L2_W+LN_W-1:0]     l3_full;
    logic signed [SUM_W-1:0]  bl_s;
    logic [L3_W-1:0]          l3mag_reg;
    logic signed [SUM_W-1:0]  s1_p3_reg;
    logic                     lneg_p3_reg;

    logic [COEF_W-1:0]        cmag;
    logic [PC_W-1:0]          pc00_reg;
    logic [PC_W-1:0]          pc01_reg;
    logic [PC_W-1:0]          pc10_reg;
    logic [PC_W-1:0]          pc11_reg;
    logic signed [SUM_W-1:0]  s1_p4_reg;
    logic                     cneg_reg;

    logic [CLF_W-1:0]         cl_full;
    logic [CL_W-1:0]          clmag;
    logic signed [SUM_W-1:0]  cl_reg;
    logic signed [SUM_W-1:0]  s1_p5_reg;

    logic signed [SUM_W-1:0]  inv_reg;
    logic                     sat_hi_next;
    logic                     sat_lo_next;
    logic [DIV_W-1:0]         dv_reg;

    logic [Q_W-1:0]           k;
    logic signed [T_W-1:0]    v;
    logic [T_W-2:0]           vmag;
    logic [T_W-18:0]          cm;
    logic signed [TMP_W-1:0]  temp_next;
    logic signed [TMP_W-1:0]  temp_reg;

    logic [NOM_W-1:0]         nom;
    logic signed [TMP_W:0]    dev;
    logic [TMP_W:0]           adev;
    logic                     alarm_next;

    logic                     out_vld_reg;
    logic signed [TMP_W-1:0]  out_temp_reg;
    logic                     out_alarm_reg;
    logic                     out_inval_reg;
    logic [CH_W-1:0]          out_chan_reg;

    assign adv  = !out_vld_reg || pop;
    assign take = adv && head_vld;

    tta_log2 u_log_hi (
        .clk (clk),
        .en  (adv),
        .x   (head.x_hi),
        .lg  (lg_hi)
    );

    tta_log2 u_log_lo (
        .clk (clk),
        .en  (adv),
        .x   (X_W'(head.x_lo)),
        .lg  (lg_lo)
    );

    tta_recip u_recip (
        .clk (clk),
        .en  (adv),
        .d   (dv_reg),
        .q   (k)
    );

    always_comb
    begin
        d_w     = $signed({1'b0, lg_hi}) - $signed({1'b0, lg_lo});
        ln_prod = (LN_W+32)'(dmag_reg) * (LN_W+32)'(LN2_Q32);
        l2_full = (2*LN_W)'(lmag_reg) * (2*LN_W)'(lmag_reg);
        bmag    = cfg.coeff_b[COEF_W-1] ? COEF_W'(-cfg.coeff_b) : COEF_W'(cfg.coeff_b);
        bl_full = ((COEF_W+LN_W)'(pb_hi_reg) << HALF) + (COEF_W+LN_W)'(pb_lo_reg);
        l3_full = ((L2_W+LN_W)'(pl_hi_reg) << L2_LO) + (L2_W+LN_W)'(pl_lo_reg);
        bl_s    = blneg_reg ? -$signed(SUM_W'(blmag_reg)) : $signed(SUM_W'(blmag_reg));
        cmag    = cfg.coeff_c[COEF_W-1] ? COEF_W'(-cfg.coeff_c) : COEF_W'(cfg.coeff_c);
        cl_full = CLF_W'(pc00_reg)
                + (CLF_W'(pc01_reg) << L3_LO)
                + (CLF_W'(pc10_reg) << HALF)
                + (CLF_W'(pc11_reg) << (HALF + L3_LO));
        clmag   = cl_full[CLF_W-1:FRAC_W];
    end

    always_comb
    begin
        sat_lo_next = inv_reg[SUM_W-1];
        sat_hi_next = !inv_reg[SUM_W-1] && (inv_reg <= $signed(SUM_W'(R_INIT)));
        cls_meta        = meta_reg[ST_INV];
        cls_meta.sat_hi = sat_hi_next;
        cls_meta.sat_lo = sat_lo_next;
    end

    always_comb
    begin
        v    = $signed({2'b00, k}) - ZERO_C;
        vmag = v[T_W-1] ? (T_W-1)'(-v) : (T_W-1)'(v);
        cm   = vmag[T_W-2:16];
        if (v[T_W-1])
            temp_next = (cm > (T_W-17)'(128)) ? TEMP_MIN : TMP_W'(-$signed({1'b0, cm}));
        else
            temp_next = (cm > (T_W-17)'(127)) ? TEMP_MAX : TMP_W'(cm);
        if (meta_reg[ST_DQ].inval)
            temp_next = '0;
        else if (meta_reg[ST_DQ].sat_hi)
            temp_next = TEMP_MAX;
        else if (meta_reg[ST_DQ].sat_lo)
            temp_next = TEMP_MIN;
    end

    always_comb
    begin
        nom        = meta_reg[ST_T].chan_ok ? cfg.nominal[meta_reg[ST_T].chan] : '0;
        dev        = $signed({temp_reg[TMP_W-1], temp_reg}) - $signed({nom[NOM_W-1], nom});
        adev       = dev[TMP_W] ? (TMP_W+1)'(-dev) : (TMP_W+1)'(dev);
        alarm_next = !meta_reg[ST_T].inval && meta_reg[ST_T].chan_ok
                     && (adev > {1'b0, cfg.threshold});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < META_N; i++)
                meta_reg[i] <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            meta_reg[0].vld     <= head_vld;
            meta_reg[0].inval   <= head.inval;
            meta_reg[0].chan_ok <= head.chan_ok;
            meta_reg[0].chan    <= head.chan;
            meta_reg[0].sat_hi  <= 1'b0;
            meta_reg[0].sat_lo  <= 1'b0;
            for (int i = 1; i < META_N; i++)
                meta_reg[i] <= (i == ST_CLS) ? cls_meta : meta_reg[i-1];
            out_vld_reg <= meta_reg[ST_T].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dneg_reg <= d_w[LOG_W];
            dmag_reg <= d_w[LOG_W] ? LN_W'(-d_w) : LN_W'(d_w);

            lmag_reg <= ln_prod[LN_W+31:32];
            lneg_reg <= dneg_reg;

            l2mag_reg   <= l2_full[2*LN_W-1:FRAC_W];
            pb_lo_reg   <= (HALF+LN_W)'(bmag[HALF-1:0]) * (HALF+LN_W)'(lmag_reg);
            pb_hi_reg   <= (HALF+LN_W)'(bmag[COEF_W-1:HALF]) * (HALF+LN_W)'(lmag_reg);
            lmag_p1_reg <= lmag_reg;
            lneg_p1_reg <= lneg_reg;

            pl_lo_reg   <= (L2_LO+LN_W)'(l2mag_reg[L2_LO-1:0]) * (L2_LO+LN_W)'(lmag_p1_reg);
            pl_hi_reg   <= (L2_LO+LN_W)'(l2mag_reg[L2_W-1:L2_LO])
                           * (L2_LO+LN_W)'(lmag_p1_reg);
            blmag_reg   <= bl_full[COEF_W+LN_W-1:FRAC_W];
            blneg_reg   <= cfg.coeff_b[COEF_W-1] ^ lneg_p1_reg;
            lneg_p2_reg <= lneg_p1_reg;

            l3mag_reg   <= l3_full[L2_W+LN_W-1:FRAC_W];
            s1_p3_reg   <= SUM_W'(cfg.coeff_a) + bl_s;
            lneg_p3_reg <= lneg_p2_reg;

            pc00_reg  <= PC_W'(cmag[HALF-1:0]) * PC_W'(l3mag_reg[L3_LO-1:0]);
            pc01_reg  <= PC_W'(cmag[HALF-1:0]) * PC_W'(l3mag_reg[L3_W-1:L3_LO]);
            pc10_reg  <= PC_W'(cmag[COEF_W-1:HALF]) * PC_W'(l3mag_reg[L3_LO-1:0]);
            pc11_reg  <= PC_W'(cmag[COEF_W-1:HALF]) * PC_W'(l3mag_reg[L3_W-1:L3_LO]);
            s1_p4_reg <= s1_p3_reg;
            cneg_reg  <= cfg.coeff_c[COEF_W-1] ^ lneg_p3_reg;

            cl_reg    <= cneg_reg ? -$signed(SUM_W'(clmag)) : $signed(SUM_W'(clmag));
            s1_p5_reg <= s1_p4_reg;

            inv_reg <= s1_p5_reg + cl_reg;

            dv_reg <= inv_reg[DIV_W-1:0];

            temp_reg <= temp_next;

            out_temp_reg  <= temp_reg;
            out_alarm_reg <= alarm_next;
            out_inval_reg <= meta_reg[ST_T].inval;
            out_chan_reg  <= meta_reg[ST_T].chan;
        end
    end

    always_comb
    begin
        res.vld         = out_vld_reg;
        res.temperature = out_temp_reg;
        res.alarm       = out_alarm_reg;
        res.inval       = out_inval_reg;
        res.chan        = out_chan_reg;
    end

endmodule

[design/thermistor_temperature_alarm.sv]
`timescale 1ns / 1ps
// Channel  Handshake        Payload
// input    push / full      adc_sample, channel
// result   empty / pop      temperature, alarm, sample_invalid, channel_out
// config   cfg_we           cfg_index, cfg_data
//
// One item per cycle while pop keeps up.
// The datapath includes the 24-step log2 squaring pipeline and the 25-step reciprocal.
// A four-entry queue parts intake from the pipeline; the pipeline stalls as a whole
// while the result register holds an untaken result.
// Reset empties queue and pipeline and loads the register defaults.

module thermistor_temperature_alarm import tta_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [ADC_BITS-1:0]      adc_sample,
    input  logic [CH_W-1:0]          channel,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [TMP_W-1:0]  temperature,
    output logic                     alarm,
    output logic                     sample_invalid,
    output logic [CH_W-1:0]          channel_out,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]        cfg_data
);

    cfg_t    cfg_reg;
    q_item_t head;
    logic    head_vld;
    logic    take;
    res_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RST;
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_COEFF_A:   cfg_reg.coeff_a    <= cfg_data;
                REG_COEFF_B:   cfg_reg.coeff_b    <= cfg_data;
                REG_COEFF_C:   cfg_reg.coeff_c    <= cfg_data;
                REG_NOM0:      cfg_reg.nominal[0] <= cfg_data[NOM_W-1:0];
                REG_NOM1:      cfg_reg.nominal[1] <= cfg_data[NOM_W-1:0];
                REG_NOM2:      cfg_reg.nominal[2] <= cfg_data[NOM_W-1:0];
                REG_THRESHOLD: cfg_reg.threshold  <= cfg_data[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    tta_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .adc_sample (adc_sample),
        .channel    (channel),
        .full       (full),
        .take       (take),
        .head       (head),
        .head_vld   (head_vld)
    );

    tta_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (head),
        .head_vld (head_vld),
        .take     (take),
        .pop      (pop),
        .res      (res)
    );

    assign empty          = !res.vld;
    assign temperature    = res.temperature;
    assign alarm          = res.alarm;
    assign sample_invalid = res.inval;
    assign channel_out    = res.chan;

endmodule

[design/tta_checker.sv]
`timescale 1ns / 1ps
`include "thermistor_temperature_alarm_macros.svh"

module tta_checker import tta_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    empty,
    input logic                    pop,
    input logic signed [TMP_W-1:0] temperature,
    input logic                    alarm,
    input logic                    sample_invalid,
    input logic [CH_W-1:0]         channel_out
);

    `TTA_ASSERT(a_inval_quiet, (!empty && sample_invalid) |-> (temperature == '0 && !alarm), "invalid sample must give zero temperature and no alarm")
    `TTA_ASSERT(a_nochan_quiet, (!empty && 32'(channel_out) >= CHANNELS) |-> !alarm, "channel without nominal raised alarm")
    `TTA_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(temperature) && $stable(alarm) && $stable(sample_invalid) && $stable(channel_out), "stalled result changed")

endmodule

bind thermistor_temperature_alarm tta_checker u_chk (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tta_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned LN2_FIX = 64'd2977044472;
    localparam longint KELVIN_ZERO = 64'd17901158;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic signed [TMP_W-1:0] temp;
        logic                    alarm;
        logic                    inval;
        logic [CH_W-1:0]         chan;
    } reading_t;

    typedef struct {
        logic [ADC_BITS-1:0] adc;
        logic [CH_W-1:0]     chan;
        bit                  fixed;
        reading_t            want;
    } sample_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic [ADC_BITS-1:0]     adc_sample;
    logic [CH_W-1:0]         channel;
    logic                    empty;
    logic                    pop = 1'b0;
    logic signed [TMP_W-1:0] temperature;
    logic                    alarm;
    logic                    sample_invalid;
    logic [CH_W-1:0]         channel_out;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [COEF_W-1:0]       cfg_data;

    longint      coef_a_m;
    longint      coef_b_m;
    longint      coef_c_m;
    longint      nominal_m [3];
    longint      thresh_m;
    reading_t    pending_readings [$];
    reading_t    head;
    int          errors = 0;
    int          burst_left;
    bit          hold_req;
    int          hold_n = 0;
    int unsigned rx_cyc = 0;

    thermistor_temperature_alarm i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .adc_sample     (adc_sample),
        .channel        (channel),
        .empty          (empty),
        .pop            (pop),
        .temperature    (temperature),
        .alarm          (alarm),
        .sample_invalid (sample_invalid),
        .channel_out    (channel_out),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned log2_fix(longint unsigned x);
        longint unsigned p;
        longint unsigned m;
        longint unsigned frac;
        p = 0;
        frac = 0;
        while (p < 63 && (x >> (p + 1)) != 0)
            p++;
        m = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
        for (int i = 0; i < FRAC_W; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (p << 24) | frac;
    endfunction

    function automatic logic [127:0] magnitude(longint v);
        logic signed [127:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic longint sign_clamp(logic [127:0] mag, bit neg);
        if (mag > MAG_LIMIT)
            mag = MAG_LIMIT;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint fix_mul(longint a, longint b, int sh);
        logic [127:0] prod;
        prod = (magnitude(a) * magnitude(b)) >> sh;
        return sign_clamp(prod, (a < 0) != (b < 0));
    endfunction

    function automatic longint clamp_add(longint a, longint b);
        logic signed [65:0] s;
        s = 66'(a) + 66'(b);
        if (s > MAG_LIMIT)
            return MAG_LIMIT;
        if (s < -MAG_LIMIT)
            return -MAG_LIMIT;
        return longint'(s);
    endfunction

    function automatic reading_t predict_reading(logic [ADC_BITS-1:0] s, logic [CH_W-1:0] ch);
        reading_t r;
        longint d;
        longint lnr;
        longint l3;
        longint inv;
        longint k;
        longint c;
        longint t;
        longint dev;
        r.temp = 0;
        r.alarm = 0;
        r.inval = 0;
        r.chan = ch;
        if (s == 0 || s == ADC_FS)
        begin
            r.inval = 1;
            return r;
        end
        d = longint'(log2_fix(64'd10000 * s)) - longint'(log2_fix(64'(ADC_FS - s)));
        lnr = sign_clamp((magnitude(d) * LN2_FIX) >> 32, d < 0);
        l3 = fix_mul(fix_mul(lnr, lnr, FRAC_W), lnr, FRAC_W);
        inv = clamp_add(clamp_add(coef_a_m, fix_mul(coef_b_m, lnr, FRAC_W)),
                        fix_mul(coef_c_m, l3, FRAC_W));
        if (inv == 0)
            t = 127;
        else if (inv < 0)
            t = -128;
        else
        begin
            k = longint'((64'd1 << 56) / longint'(unsigned'(inv)));
            c = (k - KELVIN_ZERO) / 65536;
            t = (c > 127) ? 127 : ((c < -128) ? -128 : c);
        end
        r.temp = t[7:0];
        if (ch < CHANNELS)
        begin
            dev = t - nominal_m[ch];
            if (dev < 0)
                dev = -dev;
            r.alarm = (dev > thresh_m);
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        logic [COEF_W-1:0] d;
        d = value[COEF_W-1:0];
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_COEFF_A:   coef_a_m = longint'($signed(d));
            REG_COEFF_B:   coef_b_m = longint'($signed(d));
            REG_COEFF_C:   coef_c_m = longint'($signed(d));
            REG_NOM0:      nominal_m[0] = longint'($signed(d[7:0]));
            REG_NOM1:      nominal_m[1] = longint'($signed(d[7:0]));
            REG_NOM2:      nominal_m[2] = longint'($signed(d[7:0]));
            REG_THRESHOLD: thresh_m = longint'(d[7:0]);
            default:       ;
        endcase
    endtask

    task automatic load_setting(longint a, longint b, longint c, longint n0, longint n1,
                                longint n2, longint thr);
        write_reg(REG_COEFF_A, a);
        write_reg(REG_COEFF_B, b);
        write_reg(REG_COEFF_C, c);
        write_reg(REG_NOM0, n0);
        write_reg(REG_NOM1, n1);
        write_reg(REG_NOM2, n2);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_UNUSED, {$urandom, $urandom});
    endtask

    task automatic offer(logic [ADC_BITS-1:0] s, logic [CH_W-1:0] ch, reading_t want);
        push <= 1'b1;
        adc_sample <= s;
        channel <= ch;
        do
            @(posedge clk);
        while (full);
        pending_readings.push_back(want);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
        else
            burst_left--;
    endtask

    task automatic drain;
        push <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_batch(int n);
        logic [ADC_BITS-1:0] s;
        logic [CH_W-1:0] ch;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 15))
                0:       s = 0;
                1:       s = ADC_FS;
                2:       s = $urandom_range(0, 1) ? 12'd1 : ADC_FS - 1;
                default: s = ADC_BITS'($urandom_range(1, ADC_FS - 1));
            endcase
            ch = CH_W'($urandom_range(0, 3));
            offer(s, ch, predict_reading(s, ch));
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        rx_cyc++;
        if (rst_n && pop && !empty)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected result: temperature %0d", temperature);
                errors++;
            end
            else
            begin
                head = pending_readings.pop_front();
                if (temperature !== head.temp)
                begin
                    $error("temperature: expected %0d, got %0d", head.temp, temperature);
                    errors++;
                end
                if (alarm !== head.alarm)
                begin
                    $error("alarm: expected %0d, got %0d", head.alarm, alarm);
                    errors++;
                end
                if (sample_invalid !== head.inval)
                begin
                    $error("sample_invalid: expected %0d, got %0d", head.inval, sample_invalid);
                    errors++;
                end
                if (channel_out !== head.chan)
                begin
                    $error("channel_out: expected %0d, got %0d", head.chan, channel_out);
                    errors++;
                end
            end
        end
        if (hold_req && hold_n < HOLD_CYCLES)
        begin
            hold_n++;
            pop <= 1'b0;
        end
        else
        begin
            case (rx_cyc[7:6])
                2'd0:    pop <= 1'b1;
                2'd1:    pop <= ($urandom_range(0, 3) != 0);
                2'd2:    pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        sample_row_t rows [$];
        reading_t none;
        rst_n = 0;
        push = 0;
        adc_sample = 0;
        channel = 0;
        cfg_we = 0;
        cfg_index = REG_COEFF_A;
        cfg_data = 0;
        burst_left = 0;
        hold_req = 0;
        coef_a_m = 64'd1 << 40;
        coef_b_m = 64'd1 << 40;
        coef_c_m = 64'd1 << 40;
        nominal_m = '{8, 3, 15};
        thresh_m = 10;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        none = '{0, 0, 0, 0};
        rows.push_back('{12'd0, 2'd0, 1'b1, '{0, 0, 1, 2'd0}});
        rows.push_back('{ADC_FS, 2'd1, 1'b1, '{0, 0, 1, 2'd1}});
        rows.push_back('{12'd0, 2'd3, 1'b1, '{0, 0, 1, 2'd3}});
        rows.push_back('{ADC_FS, 2'd2, 1'b1, '{0, 0, 1, 2'd2}});
        rows.push_back('{12'd1, 2'd0, 1'b0, none});
        rows.push_back('{ADC_FS - 1, 2'd1, 1'b0, none});
        rows.push_back('{12'd2, 2'd2, 1'b0, none});
        rows.push_back('{12'd2048, 2'd3, 1'b0, none});
        rows.push_back('{12'd2047, 2'd0, 1'b0, none});
        rows.push_back('{12'd1024, 2'd1, 1'b0, none});
        rows.push_back('{12'd3072, 2'd2, 1'b0, none});
        rows.push_back('{12'hAAA, 2'd0, 1'b0, none});
        rows.push_back('{12'h555, 2'd3, 1'b0, none});
        rows.push_back('{12'd100, 2'd1, 1'b0, none});
        rows.push_back('{12'd4000, 2'd2, 1'b0, none});
        foreach (rows[i])
            offer(rows[i].adc, rows[i].chan,
                  rows[i].fixed ? rows[i].want : predict_reading(rows[i].adc, rows[i].chan));
        drain();

        load_setting(64'd1241510000, 64'd257424000, 64'd96399, 25, 20, 30, 3);
        hold_req = 1'b1;
        random_batch(250);
        load_setting(64'd1241510000, 64'd257424000, 64'd96399, 127, -128, 0, 0);
        random_batch(150);
        load_setting(0, 0, 0, 127, -128, 0, 255);
        random_batch(60);
        load_setting(-(64'd1 << 47), 0, 0, -128, 127, -1, 255);
        random_batch(60);
        load_setting((64'd1 << 47) - 1, (64'd1 << 47) - 1, (64'd1 << 47) - 1, -128, 0, 5, 1);
        random_batch(60);
        load_setting(-(64'd1 << 47), (64'd1 << 47) - 1, -(64'd1 << 47), 0, 0, 0, 128);
        random_batch(60);
        load_setting(64'd1241510000, -64'd257424000, 64'd96399, 10, 50, -40, 20);
        random_batch(150);
        for (int p = 0; p < 4; p++)
        begin
            load_setting(64'd1100000000 + $urandom_range(0, 300000000),
                         64'd200000000 + $urandom_range(0, 100000000),
                         $urandom_range(0, 200000), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 40));
            random_batch(110);
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/tta_pkg.sv
design/tta_front.sv
design/tta_log2.sv
design/tta_recip.sv
design/tta_back.sv
design/thermistor_temperature_alarm.sv
design/tta_checker.sv
tb/sv/tb_top.sv
